FILE: rtl/ivs_pkg.sv
`timescale 1ns / 1ps
package ivs_pkg;

  // store geometry
  localparam int DEPTH = 64;
  localparam int WIDTH = 32;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int GRP = 8;
  localparam int NGRP = DEPTH / GRP;

  // item field widths
  localparam int DATA_W = 32;

  typedef logic [WIDTH-1:0] word_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // operation codes
  typedef enum logic [1:0] {
    FN_PUSH     = 2'd0,
    FN_POP_BACK = 2'd1,
    FN_POP_AT   = 2'd2,
    FN_READ_AT  = 2'd3
  } func_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SEL,
    S_UPD
  } ivs_state_t;

  typedef struct packed {
    func_t             func;
    logic [5:0]        index;
    logic [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] data_out;
    status_t           status;
    logic [6:0]        count_out;
  } out_item_t;

  // control broadcast to every cell
  typedef struct packed {
    logic  upd;
    func_t func;
    idx_t  idx;
    idx_t  rd_idx;
    cnt_t  cnt;
    word_t value;
  } cell_ctrl_t;

endpackage

FILE: rtl/indexed_vector_store.sv
`timescale 1ns / 1ps
// Packed word store of DEPTH cells with an element count. Each item is push
// back, pop back, pop at index or read at index and yields one result item
// with the word, a status and the new count. Cells sit in a row; a pop at
// index moves every later word down one cell at once. An item passes through
// accept, a registered gather of the addressed word across the row, then the
// cell update and the result load, held while the last result is stalled. The
// next item is accepted while the loaded result waits at the output. Cell
// contents are not reset; only positions below the count are ever read.
module indexed_vector_store (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ivs_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output ivs_pkg::out_item_t out_item
);
  import ivs_pkg::*;

  ivs_state_t state_r, state_nxt;
  in_item_t   item_r;
  cnt_t       count_r, count_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_item_r, out_item_nxt;

  cell_ctrl_t ctrl;
  word_t      cell_word [DEPTH];
  word_t      sel_word  [DEPTH];
  word_t      gathered;
  idx_t       last_idx;
  cnt_t       idx_c;
  cnt_t       last_cnt;
  status_t    status;
  logic       upd;

  assign last_cnt = count_r - cnt_t'(1);
  assign last_idx = last_cnt[IDX_W-1:0];
  assign idx_c    = cnt_t'(item_r.index);

  // status of the held item against the current count
  always_comb begin
    status = ST_OK;
    case (item_r.func)
      FN_PUSH: begin
        if (count_r >= cnt_t'(DEPTH)) status = ST_FULL;
      end
      FN_POP_BACK: begin
        if (count_r == '0) status = ST_EMPTY;
      end
      FN_POP_AT: begin
        if (count_r == '0) status = ST_EMPTY;
        else if (idx_c >= count_r) status = ST_RANGE;
      end
      default: begin
        if (idx_c >= count_r) status = ST_RANGE;
      end
    endcase
  end

  // sequencer and result load
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    upd           = 1'b0;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_SEL;
      end
      S_SEL: begin
        state_nxt = S_UPD;
      end
      S_UPD: begin
        if (!out_valid_r || !out_stall) begin
          upd       = (status == ST_OK);
          state_nxt = S_IDLE;
          if (status == ST_OK) begin
            if (item_r.func == FN_PUSH) count_nxt = count_r + cnt_t'(1);
            else if (item_r.func != FN_READ_AT) count_nxt = last_cnt;
          end
          out_valid_nxt          = 1'b1;
          out_item_nxt.status    = status;
          out_item_nxt.count_out = 7'(count_nxt);
          out_item_nxt.data_out  = (status == ST_OK && item_r.func != FN_PUSH)
                                   ? DATA_W'(gathered) : '0;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) item_r <= in_item;
    out_item_r <= out_item_nxt;
  end

  // broadcast to the row
  always_comb begin
    ctrl.upd    = upd;
    ctrl.func   = item_r.func;
    ctrl.idx    = item_r.index[IDX_W-1:0];
    ctrl.rd_idx = (item_r.func == FN_POP_BACK) ? last_idx : item_r.index[IDX_W-1:0];
    ctrl.cnt    = count_r;
    ctrl.value  = word_t'(item_r.value);
  end

  // row of cells, each fed by its upper neighbour
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    ivs_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .pos       (idx_t'(i)),
      .next_word ((i == DEPTH - 1) ? word_t'(0) : cell_word[(i + 1) % DEPTH]),
      .word      (cell_word[i]),
      .sel_word  (sel_word[i])
    );
  end

  ivs_gather u_gather (
    .clk      (clk),
    .load     (state_r == S_SEL),
    .sel_word (sel_word),
    .data     (gathered)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef SYNTHESIS
  // count never passes the capacity
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cnt_t'(DEPTH))
    else $error("count above capacity");

  // a new result only comes from the update state
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_UPD))
    else $error("result loaded outside update");

  // full is reported only with a full store
  a_full_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.status == ST_FULL) |-> (out_item_r.count_out == 7'(DEPTH)))
    else $error("full status with room left");

  // an accepted item always goes on to the gather
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_valid) |=> (state_r == S_SEL))
    else $error("accepted item lost");
`endif

endmodule

FILE: rtl/ivs_cell.sv
`timescale 1ns / 1ps
module ivs_cell (
  input  logic               clk,
  input  ivs_pkg::cell_ctrl_t ctrl,
  input  ivs_pkg::idx_t      pos,
  input  ivs_pkg::word_t     next_word,
  output ivs_pkg::word_t     word,
  output ivs_pkg::word_t     sel_word
);
  import ivs_pkg::*;

  word_t word_r;
  word_t word_nxt;
  cnt_t  pos_c;
  cnt_t  last;

  assign pos_c = {1'b0, pos};
  assign last  = ctrl.cnt - cnt_t'(1);

  // next word: append, clear the freed slot, or take the neighbour's word
  always_comb begin
    word_nxt = word_r;
    if (ctrl.upd) begin
      case (ctrl.func)
        FN_PUSH: begin
          if (pos_c == ctrl.cnt) word_nxt = ctrl.value;
        end
        FN_POP_BACK: begin
          if (pos_c == last) word_nxt = '0;
        end
        FN_POP_AT: begin
          if (pos_c == last) begin
            word_nxt = '0;
          end else if (pos >= ctrl.idx && pos_c < last) begin
            word_nxt = next_word;
          end
        end
        default: begin
          word_nxt = word_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word     = word_r;
  assign sel_word = (pos == ctrl.rd_idx) ? word_r : '0;

endmodule

FILE: rtl/ivs_gather.sv
`timescale 1ns / 1ps
module ivs_gather (
  input  logic           clk,
  input  logic           load,
  input  ivs_pkg::word_t sel_word [ivs_pkg::DEPTH],
  output ivs_pkg::word_t data
);
  import ivs_pkg::*;

  word_t part_r [NGRP];

  // first level: or each group of cells, registered
  always_ff @(posedge clk) begin
    if (load) begin
      for (int g = 0; g < NGRP; g++) begin
        word_t acc;
        acc = '0;
        for (int k = 0; k < GRP; k++) acc = acc | sel_word[g*GRP + k];
        part_r[g] <= acc;
      end
    end
  end

  // second level: or of the group results
  always_comb begin
    data = '0;
    for (int g = 0; g < NGRP; g++) data = data | part_r[g];
  end

endmodule

FILE: bench/ivs_checker.sv
`timescale 1ns / 1ps
module ivs_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  ivs_pkg::in_item_t  in_item,
  input  logic               out_valid,
  input  logic               out_stall,
  input  ivs_pkg::out_item_t out_item,
  output int                 fail_count,
  output int                 pending
);
  import ivs_pkg::*;

  // shadow copy of the stored words and the element count
  word_t     slots [DEPTH];
  cnt_t      fill;
  out_item_t awaited [$];

  initial begin
    fail_count = 0;
    pending = 0;
    fill = '0;
  end

  // apply one item to the shadow store and work out its result
  function automatic out_item_t apply_op(in_item_t it);
    out_item_t r;
    int k;
    r = '0;
    r.status = ST_OK;
    case (it.func)
      FN_PUSH: begin
        if (fill >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          slots[fill[IDX_W-1:0]] = word_t'(it.value);
          fill = fill + cnt_t'(1);
        end
      end
      FN_POP_BACK: begin
        if (fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          fill = fill - cnt_t'(1);
          r.data_out = DATA_W'(slots[fill[IDX_W-1:0]]);
          slots[fill[IDX_W-1:0]] = '0;
        end
      end
      FN_POP_AT: begin
        if (fill == 0) begin
          r.status = ST_EMPTY;
        end else if (cnt_t'(it.index) >= fill) begin
          r.status = ST_RANGE;
        end else begin
          r.data_out = DATA_W'(slots[it.index]);
          // later words close the gap
          for (k = it.index; k + 1 < fill; k++) slots[k] = slots[k+1];
          fill = fill - cnt_t'(1);
          slots[fill[IDX_W-1:0]] = '0;
        end
      end
      default: begin
        if (cnt_t'(it.index) >= fill) r.status = ST_RANGE;
        else r.data_out = DATA_W'(slots[it.index]);
      end
    endcase
    r.count_out = 7'(fill);
    return r;
  endfunction

  // compare results first, then queue the expectation of a new item
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      awaited.delete();
      fill = '0;
      foreach (slots[k]) slots[k] = '0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited.size() == 0) begin
          $error("result item with nothing outstanding: data_out %h status %0d count_out %0d",
                 out_item.data_out, out_item.status, out_item.count_out);
          fail_count++;
        end else begin
          want = awaited.pop_front();
          if (out_item.data_out !== want.data_out) begin
            $error("data_out mismatch: expected %h, got %h", want.data_out, out_item.data_out);
            fail_count++;
          end
          if (out_item.status !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, out_item.status);
            fail_count++;
          end
          if (out_item.count_out !== want.count_out) begin
            $error("count_out mismatch: expected %0d, got %0d",
                   want.count_out, out_item.count_out);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) awaited.push_back(apply_op(in_item));
    end
    pending = awaited.size();
  end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import ivs_pkg::*;

  localparam int LIMIT = 200000;
  localparam int HOLD_CYCLES = 150;
  localparam int PHASE_ITEMS = 195;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;
  int        fail_count;
  int        pending;

  int send_idle = 0;
  int stall_pct = 0;
  int hold_reqs = 0;
  int hold_taken = 0;
  int hold_left = 0;
  int cycles = 0;
  int level = 0;

  indexed_vector_store uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  ivs_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else if (hold_taken != hold_reqs) begin
      hold_taken++;
      hold_left = HOLD_CYCLES - 1;
      out_stall = 1'b1;
    end else begin
      out_stall = ($urandom_range(99) < stall_pct);
    end
  end

  // offer one item and wait until it is taken; tracks the fill level for shaping
  task automatic issue(input func_t f, input int unsigned idx, input logic [31:0] v);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_item.func = f;
    in_item.index = 6'(idx);
    in_item.value = v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    case (f)
      FN_PUSH:     if (level < DEPTH) level++;
      FN_POP_BACK: if (level > 0) level--;
      FN_POP_AT:   if (idx < level) level--;
      default:     ;
    endcase
  endtask

  initial begin
    int p;
    int n;
    int roll;
    int unsigned idx;
    logic [31:0] v;
    bit rising;
    func_t f;
    int idle_tab [4];
    int stall_tab [4];

    idle_tab = '{0, 56, 0, 21};
    stall_tab = '{0, 0, 56, 21};

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty store: every removal and read fails
    issue(FN_POP_BACK, 0, 32'h0);
    issue(FN_POP_AT, 63, 32'hFFFF_FFFF);
    issue(FN_POP_AT, 0, 32'h0);
    issue(FN_READ_AT, 0, 32'h0);
    // extreme words, then reads inside and past the end
    issue(FN_PUSH, 63, 32'h0000_0000);
    issue(FN_PUSH, 0, 32'hFFFF_FFFF);
    issue(FN_PUSH, 0, 32'h1234_5678);
    issue(FN_PUSH, 0, 32'h8000_0001);
    issue(FN_READ_AT, 0, 32'h0);
    issue(FN_READ_AT, 3, 32'h0);
    issue(FN_READ_AT, 4, 32'h0);
    issue(FN_READ_AT, 63, 32'h0);
    issue(FN_POP_AT, 4, 32'h0);
    issue(FN_POP_AT, 63, 32'h0);
    // middle removal shifts the tail down, then front removal
    issue(FN_POP_AT, 1, 32'h0);
    issue(FN_READ_AT, 1, 32'h0);
    issue(FN_READ_AT, 2, 32'h0);
    issue(FN_POP_AT, 0, 32'h0);
    issue(FN_READ_AT, 0, 32'h0);
    issue(FN_POP_BACK, 0, 32'h0);
    issue(FN_POP_BACK, 0, 32'h0);
    issue(FN_POP_BACK, 0, 32'h0);
    issue(FN_POP_AT, 0, 32'h0);

    // random phases: fill towards full, then drain towards empty
    rising = 1'b1;
    for (p = 0; p < 4; p++) begin
      send_idle = idle_tab[p];
      stall_pct = stall_tab[p];
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 0 && n == 60) hold_reqs++;
        if (level >= DEPTH && $urandom_range(3) == 0) rising = 1'b0;
        else if (level == 0) rising = 1'b1;
        roll = $urandom_range(99);
        case ($urandom_range(7))
          0:       v = 32'h0;
          1:       v = 32'hFFFF_FFFF;
          default: v = $urandom;
        endcase
        if (level > 0 && $urandom_range(4) != 0) idx = $urandom_range(level - 1);
        else idx = $urandom_range(63);
        if (roll < 8) begin
          f = func_t'($urandom_range(3));
        end else if (rising ? (roll < 80) : (roll < 28)) begin
          f = FN_PUSH;
        end else begin
          f = func_t'($urandom_range(3, 1));
        end
        issue(f, idx, v);
      end
    end

    @(negedge clk);
    in_valid = 1'b0;
    stall_pct = 0;
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: indexed_vector_store.f
rtl/ivs_pkg.sv
rtl/ivs_cell.sv
rtl/ivs_gather.sv
rtl/indexed_vector_store.sv
bench/ivs_checker.sv
bench/testbench.sv
